FILE: sv/qoi_dec_pkg.sv
// Package with the shared types, codes and the color hash of the QOI byte stream decoder.
package qoi_dec_pkg;

  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam int COUNT_W  = 32;
  localparam int RUN_W    = 6;
  localparam int HASH_W   = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

  // Chunk tags in the two top bits of an opcode byte.
  localparam logic [1:0] OP_INDEX = 2'b00;
  localparam logic [1:0] OP_DIFF  = 2'b01;
  localparam logic [1:0] OP_LUMA  = 2'b10;

  // Run field values that announce an RGB or RGBA chunk instead of a run.
  localparam logic [RUN_W-1:0] RUN_FIELD_RGB = 6'd62;

  localparam logic [BYTE_W-1:0] LUMA_BIAS  = 8'd224;
  localparam logic [BYTE_W-1:0] OPAQUE     = 8'd255;

  typedef struct packed {
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] g;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] a;
  } pixel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_IDXWAIT,
    S_RUN
  } state_t;

  typedef enum logic [2:0] {
    PH_OPCODE = 3'd0,
    PH_LUMA   = 3'd1,
    PH_RED    = 3'd2,
    PH_GREEN  = 3'd3,
    PH_BLUE   = 3'd4,
    PH_ALPHA  = 3'd5
  } phase_t;

  // Color hash 3r + 5g + 7b + 11a; the caller keeps the low index bits.
  function automatic logic [HASH_W-1:0] px_hash(pixel_t p);
    logic [HASH_W-1:0] sum;
    sum = HASH_W'(p.r) * HASH_W'(3) + HASH_W'(p.g) * HASH_W'(5)
        + HASH_W'(p.b) * HASH_W'(7) + HASH_W'(p.a) * HASH_W'(11);
    return sum;
  endfunction

endpackage

FILE: sv/qoi_dec_in_if.sv
// Input channel interface that carries one stream byte per item.
interface qoi_dec_in_if;
  import qoi_dec_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              start_image;

  modport source (output valid, output data_byte, output start_image, input ready);
  modport sink   (input valid, input data_byte, input start_image, output ready);
endinterface

FILE: sv/qoi_dec_out_if.sv
// Result channel interface that carries one decoded RGBA pixel per item.
interface qoi_dec_out_if;
  import qoi_dec_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [BYTE_W-1:0] alpha;
  logic              last_of_byte;
  logic              image_done;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output last_of_byte, output image_done, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input last_of_byte, input image_done, output ready);
endinterface

FILE: sv/qoi_dec_cfg_if.sv
// Configuration write channel interface with a register index and write data.
interface qoi_dec_cfg_if;
  import qoi_dec_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: sv/qoi_byte_stream_decoder_core.sv
// QOI chunk stream decoder: one byte per item in, RGBA pixels out, color index in a memory.
// A one-pixel chunk writes its pixel to the output register from the decode state; an
// INDEX chunk does so from the wait state, after a registered read of the index memory.
// A new byte is taken only in the idle state, once the previous one is through; a run of n
// pixels is emitted by the run sequencer one per cycle while the output does not stall.
// Reset (synchronous, rst_n low) clears control state and the index valid bits, so
// every index entry reads as zero until written; memory contents are not swept.
module qoi_byte_stream_decoder_core #(
  parameter int INDEX_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  qoi_dec_in_if.sink           in_ch,
  qoi_dec_out_if.source        out_ch,
  qoi_dec_cfg_if.sink          cfg_ch
);
  import qoi_dec_pkg::*;

  localparam int IDX_W = $clog2(INDEX_ENTRIES);

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [BYTE_W-1:0]    pend_dg_r, pend_dg_nxt;
  logic                 alpha_fol_r, alpha_fol_nxt;
  pixel_t               prev_r, prev_nxt;
  logic [COUNT_W-1:0]   rem_r, rem_nxt;
  logic [RUN_W-1:0]     run_cnt_r, run_cnt_nxt;
  logic [BYTE_W-1:0]    byte_r;
  logic                 start_r;
  logic [CFG_DAT_W-1:0] width_r;
  logic [CFG_DAT_W-1:0] height_r;
  logic [INDEX_ENTRIES-1:0] valid_r;

  logic                 out_valid_r;
  pixel_t               out_px_r;
  logic                 out_last_r;
  logic                 out_done_r;

  pixel_t               idx_mem [INDEX_ENTRIES];
  pixel_t               rd_data_r;
  logic                 rd_valid_r;

  logic                 in_acc;
  logic                 emit_ok;
  logic                 need_emit;
  logic                 adv;
  logic                 emit;
  logic                 emit_last;
  logic                 rd_en;
  logic                 start_run;
  pixel_t               px_new;
  logic [HASH_W-1:0]    px_sum;
  logic [IDX_W-1:0]     wr_addr;
  logic [RUN_W:0]       run_len;
  logic [COUNT_W-1:0]   rem_dec;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign emit_ok     = !out_valid_r || out_ch.ready;
  assign run_len     = {1'b0, byte_r[RUN_W-1:0]} + (RUN_W+1)'(1);
  assign rem_dec     = rem_r - COUNT_W'(rem_r != '0);
  assign px_sum      = px_hash(px_new);
  assign wr_addr     = px_sum[IDX_W-1:0];

  // Chunk decode: candidate pixel and whether this cycle produces a result.
  always_comb begin
    px_new        = prev_r;
    need_emit     = 1'b0;
    emit_last     = 1'b1;
    rd_en         = 1'b0;
    start_run     = 1'b0;
    phase_nxt     = phase_r;
    pend_dg_nxt   = pend_dg_r;
    alpha_fol_nxt = alpha_fol_r;
    run_cnt_nxt   = run_cnt_r;
    case (state_r)
      S_EXEC: begin
        case (phase_r)
          PH_LUMA: begin
            px_new.r  = prev_r.r + pend_dg_r + {4'd0, byte_r[7:4]} - 8'd8;
            px_new.g  = prev_r.g + pend_dg_r;
            px_new.b  = prev_r.b + pend_dg_r + {4'd0, byte_r[3:0]} - 8'd8;
            need_emit = 1'b1;
            phase_nxt = PH_OPCODE;
          end
          PH_RED: begin
            px_new.r  = byte_r;
            phase_nxt = PH_GREEN;
          end
          PH_GREEN: begin
            px_new.g  = byte_r;
            phase_nxt = PH_BLUE;
          end
          PH_BLUE: begin
            px_new.b = byte_r;
            if (alpha_fol_r) begin
              phase_nxt = PH_ALPHA;
            end else begin
              phase_nxt = PH_OPCODE;
              need_emit = 1'b1;
            end
          end
          PH_ALPHA: begin
            px_new.a  = byte_r;
            phase_nxt = PH_OPCODE;
            need_emit = 1'b1;
          end
          default: begin
            // Opcode byte; ignored once the image is complete.
            phase_nxt = PH_OPCODE;
            if (rem_r != '0) begin
              case (byte_r[7:6])
                OP_INDEX: begin
                  rd_en = 1'b1;
                end
                OP_DIFF: begin
                  px_new.r  = prev_r.r + {6'd0, byte_r[5:4]} - 8'd2;
                  px_new.g  = prev_r.g + {6'd0, byte_r[3:2]} - 8'd2;
                  px_new.b  = prev_r.b + {6'd0, byte_r[1:0]} - 8'd2;
                  need_emit = 1'b1;
                end
                OP_LUMA: begin
                  pend_dg_nxt = {2'd0, byte_r[5:0]} + LUMA_BIAS;
                  phase_nxt   = PH_LUMA;
                end
                default: begin
                  if (byte_r[RUN_W-1:0] >= RUN_FIELD_RGB) begin
                    alpha_fol_nxt = byte_r[0];
                    phase_nxt     = PH_RED;
                  end else begin
                    // Clamp the run to the pixels that remain.
                    start_run = 1'b1;
                    if (COUNT_W'(run_len) > rem_r) begin
                      run_cnt_nxt = rem_r[RUN_W-1:0];
                    end else begin
                      run_cnt_nxt = run_len[RUN_W-1:0];
                    end
                  end
                end
              endcase
            end
          end
        endcase
      end
      S_IDXWAIT: begin
        px_new    = rd_valid_r ? rd_data_r : '0;
        need_emit = 1'b1;
      end
      S_RUN: begin
        need_emit   = 1'b1;
        emit_last   = (run_cnt_r == RUN_W'(1));
        run_cnt_nxt = run_cnt_r - RUN_W'(1);
      end
      default: begin
        need_emit = 1'b0;
      end
    endcase
  end

  assign adv  = !need_emit || emit_ok;
  assign emit = need_emit && adv;

  // Next state of the byte sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (adv) begin
          if (rd_en) begin
            state_nxt = S_IDXWAIT;
          end else if (start_run) begin
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDXWAIT: begin
        if (adv) begin
          state_nxt = S_IDLE;
        end
      end
      S_RUN: begin
        if (adv && run_cnt_r == RUN_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Next values of the decoder state; a start byte reinitializes the image.
  always_comb begin
    prev_nxt = prev_r;
    rem_nxt  = rem_r;
    if (state_r == S_IDLE) begin
      if (in_acc && in_ch.start_image) begin
        prev_nxt = '{r: '0, g: '0, b: '0, a: OPAQUE};
        rem_nxt  = COUNT_W'(width_r) * COUNT_W'(height_r);
      end
    end else if (adv) begin
      prev_nxt = px_new;
      if (emit) begin
        rem_nxt = rem_dec;
      end
    end
  end

  // Sequencer and decoder state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_OPCODE;
      pend_dg_r   <= '0;
      alpha_fol_r <= 1'b0;
      prev_r      <= '{r: '0, g: '0, b: '0, a: OPAQUE};
      rem_r       <= '0;
      run_cnt_r   <= '0;
      valid_r     <= '0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      rem_r   <= rem_nxt;
      if (state_r == S_IDLE) begin
        if (in_acc && in_ch.start_image) begin
          phase_r     <= PH_OPCODE;
          pend_dg_r   <= '0;
          alpha_fol_r <= 1'b0;
          valid_r     <= '0;
        end
      end else if (adv) begin
        phase_r     <= phase_nxt;
        pend_dg_r   <= pend_dg_nxt;
        alpha_fol_r <= alpha_fol_nxt;
        run_cnt_r   <= run_cnt_nxt;
        if (emit) begin
          valid_r[wr_addr] <= 1'b1;
        end
      end
    end
  end

  // Captured input byte.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r  <= in_ch.data_byte;
      start_r <= in_ch.start_image;
    end
  end

  // Color index memory: one write per emitted pixel, one registered read for INDEX.
  always_ff @(posedge clk) begin
    if (emit) begin
      idx_mem[wr_addr] <= px_new;
    end
    if (rd_en && adv) begin
      rd_data_r  <= idx_mem[byte_r[IDX_W-1:0]];
      rd_valid_r <= valid_r[byte_r[IDX_W-1:0]];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_px_r   <= px_new;
      out_last_r <= emit_last;
      out_done_r <= (rem_dec == '0);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.red          = out_px_r.r;
  assign out_ch.green        = out_px_r.g;
  assign out_ch.blue         = out_px_r.b;
  assign out_ch.alpha        = out_px_r.a;
  assign out_ch.last_of_byte = out_last_r;
  assign out_ch.image_done   = out_done_r;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.reg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_ch.wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_ch.wdata;
        default: begin
        end
      endcase
    end
  end

  // A run in progress always has at least one pixel left to emit.
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> run_cnt_r != '0)
    else $error("run sequencer active with an empty count");

  // The final run copy, and only it, is flagged as the last pixel of the byte.
  a_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && emit) |=> out_ch.last_of_byte == $past(run_cnt_r == RUN_W'(1)))
    else $error("run last flag does not match the run count");

  // The image-done flag follows the pixel counter reaching zero.
  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_ch.valid && (out_ch.image_done == (rem_r == '0)))
    else $error("image done flag disagrees with the pixel counter");

  // The index wait state is entered only from a decode step that issued the memory read.
  a_idx_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDXWAIT && $past(state_r) != S_IDXWAIT) |-> $past(state_r == S_EXEC && rd_en))
    else $error("index wait entered without a memory read");

  // A start byte reaches the decode step with the image state reinitialized.
  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && $past(state_r) == S_IDLE && start_r) |->
      (phase_r == PH_OPCODE && valid_r == '0))
    else $error("start byte decoded without clearing the image state");

endmodule

FILE: dv/qoi_byte_stream_decoder_core_tb.sv
// Self-checking testbench for the QOI byte stream decoder: directed table, empty images, random chunk streams.
module qoi_byte_stream_decoder_core_tb;
  import qoi_dec_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int SLOTS           = 64;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int DIRECTED_ROWS   = 25;

  localparam logic [1:0]           OP_RUN       = 2'b11;
  localparam logic [BYTE_W-1:0]    TAG_RGB      = {OP_RUN, RUN_FIELD_RGB};
  localparam logic [BYTE_W-1:0]    TAG_RGBA     = {OP_RUN, RUN_FIELD_RGB + 6'd1};
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;

  typedef struct packed {
    pixel_t px;
    logic   last;
    logic   done;
  } pixel_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
    logic              typed;
    pixel_t            px;
    logic              last;
    logic              done;
  } stim_row_t;

  // Directed rows for a 4 x 3 image. Pixels are written as {r, g, b, a}.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, 32'h00000000, 1'b1, 1'b0},  // index hit on a cleared slot
    '{8'h40, 1'b0, 1'b1, 32'hFEFEFE00, 1'b1, 1'b0},  // smallest diff wraps below zero
    '{8'h7F, 1'b0, 1'b1, 32'hFFFFFF00, 1'b1, 1'b0},  // largest diff
    '{8'h80, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},  // luma, smallest green delta
    '{8'h00, 1'b0, 1'b1, 32'hD7DFD700, 1'b1, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},  // luma, largest green delta
    '{8'hFF, 1'b0, 1'b1, 32'hFDFEFD00, 1'b1, 1'b0},
    '{8'hFE, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},  // RGB chunk
    '{8'h12, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},
    '{8'h34, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},
    '{8'h56, 1'b0, 1'b1, 32'h12345600, 1'b1, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},  // RGBA chunk
    '{8'hAB, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},
    '{8'hCD, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},
    '{8'hEF, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b1, 32'hABCDEF80, 1'b1, 1'b0},
    '{8'hC0, 1'b0, 1'b1, 32'hABCDEF80, 1'b1, 1'b0},  // run of one
    '{8'hFD, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},  // longest run, clamped to the image
    '{8'h00, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},  // end marker bytes are ignored
    '{8'h01, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},
    '{8'hFE, 1'b1, 1'b0, 32'h00000000, 1'b0, 1'b0},  // new image, RGB left unfinished
    '{8'h01, 1'b0, 1'b0, 32'h00000000, 1'b0, 1'b0},
    '{8'hC1, 1'b1, 1'b0, 32'h00000000, 1'b0, 1'b0},  // restart inside the chunk, run of two
    '{8'h35, 1'b0, 1'b1, 32'h000000FF, 1'b1, 1'b0},  // slot of the opaque black pixel
    '{8'h3F, 1'b0, 1'b1, 32'h00000000, 1'b1, 1'b0}   // slot never written since the restart
  };

  // Random phases: sender idle and receiver stall percentages, image size.
  localparam int          SET_GAP    [PHASES] = '{0, 57, 0, 7, 0, 57, 0, 7};
  localparam int          SET_STALL  [PHASES] = '{0, 0, 57, 7, 0, 0, 57, 7};
  localparam logic [15:0] SET_WIDTH  [PHASES] = '{16'd3, 16'd65535, 16'd7, 16'd65535,
                                                  16'd2, 16'd16, 16'd5, 16'd1};
  localparam logic [15:0] SET_HEIGHT [PHASES] = '{16'd5, 16'd65535, 16'd2, 16'd1,
                                                  16'd1, 16'd16, 16'd3, 16'd1};

  logic clk;
  logic rst_n;

  qoi_dec_in_if  in_ch();
  qoi_dec_out_if out_ch();
  qoi_dec_cfg_if cfg_ch();

  qoi_byte_stream_decoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Decoder state kept by the testbench.
  logic [15:0]       img_w;
  logic [15:0]       img_h;
  phase_t            dec_phase;
  logic [BYTE_W-1:0] luma_dg;
  logic              alpha_next;
  pixel_t            prev_px;
  pixel_t            color_idx [SLOTS];
  logic [31:0]       px_left;

  pixel_result_t pixel_q [$];

  int   gap_pct;
  int   stall_pct;
  int   errors;
  int   pixels_checked;
  int   items_fed;
  int   bytes_ignored;
  int   settings_done;
  int   cycle_cnt;
  logic restart_pending;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [5:0] slot_of(pixel_t p);
    int h;
    h = 3 * int'(p.r) + 5 * int'(p.g) + 7 * int'(p.b) + 11 * int'(p.a);
    return h[5:0];
  endfunction

  function automatic void clear_image();
    dec_phase  = PH_OPCODE;
    luma_dg    = '0;
    alpha_next = 1'b0;
    prev_px    = {8'd0, 8'd0, 8'd0, OPAQUE};
    for (int i = 0; i < SLOTS; i++) color_idx[i] = '0;
  endfunction

  // The current pixel goes out, into the index, and off the pixel count.
  function automatic void emit_pixel(logic last);
    pixel_result_t res;
    color_idx[slot_of(prev_px)] = prev_px;
    if (px_left != 0) px_left--;
    res.px   = prev_px;
    res.last = last;
    res.done = (px_left == 0);
    pixel_q.push_back(res);
  endfunction

  // Decodes one accepted stream byte and queues the pixels it produces.
  function automatic void decode_byte(logic [BYTE_W-1:0] b, logic start);
    logic [5:0] run_field;
    int         run_len;
    if (start) begin
      clear_image();
      px_left = 32'(img_w) * 32'(img_h);
    end
    // Operand bytes of a multi-byte chunk.
    case (dec_phase)
      PH_LUMA: begin
        prev_px.r = prev_px.r + luma_dg + {4'd0, b[7:4]} - 8'd8;
        prev_px.g = prev_px.g + luma_dg;
        prev_px.b = prev_px.b + luma_dg + {4'd0, b[3:0]} - 8'd8;
        dec_phase = PH_OPCODE;
        items_fed++;
        emit_pixel(1'b1);
        return;
      end
      PH_RED: begin
        prev_px.r = b;
        dec_phase = PH_GREEN;
        items_fed++;
        return;
      end
      PH_GREEN: begin
        prev_px.g = b;
        dec_phase = PH_BLUE;
        items_fed++;
        return;
      end
      PH_BLUE: begin
        prev_px.b = b;
        items_fed++;
        if (alpha_next) begin
          dec_phase = PH_ALPHA;
          return;
        end
        dec_phase = PH_OPCODE;
        emit_pixel(1'b1);
        return;
      end
      PH_ALPHA: begin
        prev_px.a = b;
        dec_phase = PH_OPCODE;
        items_fed++;
        emit_pixel(1'b1);
        return;
      end
      default: ;
    endcase
    dec_phase = PH_OPCODE;
    // Opcode bytes past the end of the image have no effect.
    if (px_left == 0) begin
      bytes_ignored++;
      return;
    end
    items_fed++;
    case (b[7:6])
      OP_INDEX: begin
        prev_px = color_idx[b[5:0]];
        emit_pixel(1'b1);
      end
      OP_DIFF: begin
        prev_px.r = prev_px.r + {6'd0, b[5:4]} - 8'd2;
        prev_px.g = prev_px.g + {6'd0, b[3:2]} - 8'd2;
        prev_px.b = prev_px.b + {6'd0, b[1:0]} - 8'd2;
        emit_pixel(1'b1);
      end
      OP_LUMA: begin
        luma_dg   = {2'd0, b[5:0]} + LUMA_BIAS;
        dec_phase = PH_LUMA;
      end
      default: begin
        run_field = b[5:0];
        if (run_field >= RUN_FIELD_RGB) begin
          alpha_next = run_field[0];
          dec_phase  = PH_RED;
        end else begin
          run_len = int'(run_field) + 1;
          if (run_len > px_left) run_len = int'(px_left);
          for (int i = 0; i < run_len; i++) emit_pixel(i == run_len - 1);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Result monitor: every accepted pixel is matched against the oldest expectation.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pixel_q.size() == 0) begin
        $error("pixel (%0d,%0d,%0d,%0d) arrived with none expected",
               out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        check_field("red", want.px.r, out_ch.red);
        check_field("green", want.px.g, out_ch.green);
        check_field("blue", want.px.b, out_ch.blue);
        check_field("alpha", want.px.a, out_ch.alpha);
        check_field("last_of_byte", 8'(want.last), 8'(out_ch.last_of_byte));
        check_field("image_done", 8'(want.done), 8'(out_ch.image_done));
        pixels_checked++;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (rst_n) out_ch.ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Run time limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected", cycle_cnt, pixel_q.size());
      $display("qoi_byte_stream_decoder_core regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid     = 1'b1;
    cfg_ch.reg_index = idx;
    cfg_ch.wdata     = val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = val;
      CFG_IMAGE_HEIGHT: img_h = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] w, input logic [15:0] h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    settings_done++;
  endtask

  // Sends one stream byte, with random sender idle cycles in front of it.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
    if (gap_pct != 0) begin
      while ($urandom_range(99) < gap_pct) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.data_byte   = b;
    in_ch.start_image = start;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    decode_byte(b, start);
  endtask

  // Stops sending until every expected pixel has come out and the block has gone quiet.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One chunk with random content; now and then a stray byte or a chunk cut short.
  task automatic feed_chunk();
    int                pick;
    int                n_ops;
    logic              start;
    logic [BYTE_W-1:0] tag;
    start           = restart_pending || ($urandom_range(99) < 3);
    restart_pending = 1'b0;
    pick            = $urandom_range(99);
    n_ops           = 0;
    if (pick < 15) begin
      if ($urandom_range(1)) tag = {OP_INDEX, slot_of(prev_px)};
      else tag = {OP_INDEX, 6'($urandom_range(63))};
    end else if (pick < 35) begin
      tag = {OP_DIFF, 6'($urandom_range(63))};
    end else if (pick < 52) begin
      tag   = {OP_LUMA, 6'($urandom_range(63))};
      n_ops = 1;
    end else if (pick < 62) begin
      tag   = TAG_RGB;
      n_ops = 3;
    end else if (pick < 70) begin
      tag   = TAG_RGBA;
      n_ops = 4;
    end else if (pick < 93) begin
      if ($urandom_range(99) < 80) tag = {OP_RUN, 6'($urandom_range(7))};
      else tag = {OP_RUN, 6'($urandom_range(61))};
    end else if ($urandom_range(1)) begin
      tag = 8'($urandom_range(255));
    end else begin
      case ($urandom_range(2))
        0: tag = {OP_LUMA, 6'($urandom_range(63))};
        1: tag = TAG_RGB;
        default: tag = TAG_RGBA;
      endcase
      n_ops           = (tag == TAG_RGBA) ? $urandom_range(3) :
                        (tag == TAG_RGB) ? $urandom_range(2) : 0;
      restart_pending = 1'b1;
    end
    send_byte(tag, start);
    repeat (n_ops) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  initial begin
    int   target;
    logic paused;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.start_image = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.reg_index  = '0;
    cfg_ch.wdata      = '0;
    gap_pct           = 0;
    stall_pct         = 0;
    errors            = 0;
    pixels_checked    = 0;
    items_fed         = 0;
    bytes_ignored     = 0;
    settings_done     = 0;
    cycle_cnt         = 0;
    restart_pending   = 1'b1;
    img_w             = '0;
    img_h             = '0;
    px_left           = '0;
    clear_image();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed table; typed rows replace the computed expectation.
    apply_setting(16'd4, 16'd3);
    write_reg(CFG_UNMAPPED, 16'($urandom));
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_byte(DIRECTED[i].data, DIRECTED[i].start);
      if (DIRECTED[i].typed)
        pixel_q[pixel_q.size() - 1] = '{DIRECTED[i].px, DIRECTED[i].last, DIRECTED[i].done};
    end
    drain();

    // Empty images: every byte is ignored.
    for (int e = 0; e < 2; e++) begin
      apply_setting((e == 0) ? 16'd0 : 16'd65535, (e == 0) ? 16'd65535 : 16'd0);
      send_byte(8'($urandom_range(255)), 1'b1);
      repeat (6) send_byte(8'($urandom_range(255)), 1'b0);
      drain();
    end

    // Random chunk streams under each idling mode.
    for (int p = 0; p < PHASES; p++) begin
      gap_pct         = SET_GAP[p];
      stall_pct       = SET_STALL[p];
      apply_setting(SET_WIDTH[p], SET_HEIGHT[p]);
      restart_pending = 1'b1;
      target          = items_fed + ITEMS_PER_PHASE;
      paused          = 1'b0;
      while (items_fed < target) begin
        // Image complete: a few trailing bytes, then a new image.
        if (!restart_pending && px_left == 0 && dec_phase == PH_OPCODE) begin
          repeat ($urandom_range(2)) send_byte(8'h00, 1'b0);
          restart_pending = 1'b1;
        end
        feed_chunk();
        if (!paused && items_fed >= target - ITEMS_PER_PHASE / 2) begin
          paused = 1'b1;
          drain();
        end
      end
      drain();
    end

    $display("Decoded %0d stream bytes and skipped %0d trailing bytes under %0d image sizes;",
             items_fed, bytes_ignored, settings_done);
    $display("%0d pixels compared, %0d mismatches, %0d cycles.", pixels_checked, errors,
             cycle_cnt);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("qoi_byte_stream_decoder_core regression: pass");
    end else begin
      $display("qoi_byte_stream_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
